FILE: rtl/core/cfcd_pkg.sv
// shared types, codes and the crc-8 byte step for the can frame checker
package cfcd_pkg;

  localparam int unsigned NumCells  = 9;
  localparam int unsigned QueueW    = 8 * NumCells;
  localparam logic [7:0]  CrcPoly   = 8'h31;
  localparam logic [28:0] StdIdMax  = 29'h7FF;
  localparam logic [7:0]  PctMax    = 8'd100;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned CfgIndexW = 3;

  typedef enum logic [2:0] {
    KIND_REJECT    = 3'd0,
    KIND_CONTROL   = 3'd1,
    KIND_HEARTBEAT = 3'd2,
    KIND_DIAG      = 3'd3,
    KIND_E2E       = 3'd4,
    KIND_SESSION   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    WHY_NONE    = 3'd0,
    WHY_UNKNOWN = 3'd1,
    WHY_CRC     = 3'd2,
    WHY_RANGE   = 3'd3,
    WHY_VERSION = 3'd4
  } reason_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_CONTROL_ID   = 3'd0,
    CFG_HEARTBEAT_ID = 3'd1,
    CFG_DIAG_ID      = 3'd2,
    CFG_E2E_ID       = 3'd3,
    CFG_SESSION_ID   = 3'd4,
    CFG_PROTO_VER    = 3'd5,
    CFG_MAX_ACK      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [28:0] can_id;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         message_kind;
    logic [2:0]         reject_reason;
    logic [7:0]         computed_crc;
    logic signed [15:0] first_word;
    logic signed [15:0] second_word;
    logic [31:0]        session_number;
    logic [55:0]        payload;
  } out_word_t;

  typedef struct packed {
    logic [10:0] control_id;
    logic [10:0] heartbeat_id;
    logic [10:0] diag_id;
    logic [10:0] e2e_id;
    logic [10:0] status_id;
    logic [7:0]  proto_ver;
    logic [7:0]  max_ack;
  } cfg_t;

  // result of the identifier and per-type checks, crc still pending
  typedef struct packed {
    kind_t   kind;
    logic    id_bad;
    reason_t type_why;
  } cls_t;

  // what travels from cell to cell
  typedef struct packed {
    logic [QueueW-1:0] queue;
    logic [7:0]        crc;
    in_word_t          frame;
    cls_t              cls;
  } lane_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/can_frame_crc8_check_decode.sv
// top level: config registers, classifier, crc cell chain and result assembly
//
// Each frame passes through a row of nine crc cells, one cell per byte of the
// crc input (two identifier bytes, then data bytes 0 to 6); the last cell is
// the output register. A new frame is taken every cycle while the output is
// not stalled. A stall on the output holds the whole row, so in_stall
// follows out_stall whenever a result is waiting. Identifier matching and
// type checks are done on entry against the registers, which must only be
// written while idle.
module can_frame_crc8_check_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cfcd_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cfcd_pkg::out_word_t                 out_word,
  input  logic                                cfg_wr_en,
  input  logic [cfcd_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [cfcd_pkg::CfgDataW-1:0]       cfg_wdata
);
  import cfcd_pkg::*;

  cfg_t    cfg_r;
  cls_t    cls;
  lane_t   lane_head;
  logic    adv;
  logic    vld [NumCells];
  lane_t   lane [NumCells];
  lane_t   last;
  reason_t why;
  in_word_t fr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CONTROL_ID:   cfg_r.control_id   <= cfg_wdata;
        CFG_HEARTBEAT_ID: cfg_r.heartbeat_id <= cfg_wdata;
        CFG_DIAG_ID:      cfg_r.diag_id      <= cfg_wdata;
        CFG_E2E_ID:       cfg_r.e2e_id       <= cfg_wdata;
        CFG_SESSION_ID:   cfg_r.status_id    <= cfg_wdata;
        CFG_PROTO_VER:    cfg_r.proto_ver    <= cfg_wdata[7:0];
        CFG_MAX_ACK:      cfg_r.max_ack      <= cfg_wdata[7:0];
        default:          ;
      endcase
    end
  end

  cfcd_classify u_classify (
    .frame (in_word),
    .cfg   (cfg_r),
    .cls   (cls)
  );

  // the row only moves when the output word is free or being taken
  assign adv      = !(vld[NumCells-1] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    lane_head.queue = {in_word.byte_6, in_word.byte_5, in_word.byte_4, in_word.byte_3,
                       in_word.byte_2, in_word.byte_1, in_word.byte_0,
                       in_word.can_id[15:8], in_word.can_id[7:0]};
    lane_head.crc   = 8'd0;
    lane_head.frame = in_word;
    lane_head.cls   = cls;
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    if (g == 0) begin : g_head
      cfcd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_in (in_valid),
        .lane_in  (lane_head),
        .valid_r  (vld[g]),
        .lane_r   (lane[g])
      );
    end else begin : g_body
      cfcd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_in (vld[g-1]),
        .lane_in  (lane[g-1]),
        .valid_r  (vld[g]),
        .lane_r   (lane[g])
      );
    end
  end

  assign last      = lane[NumCells-1];
  assign fr        = last.frame;
  assign out_valid = vld[NumCells-1];

  // identifier first, then crc, then the per-type check
  always_comb begin
    priority if (last.cls.id_bad) begin
      why = WHY_UNKNOWN;
    end else if (last.crc != fr.byte_7) begin
      why = WHY_CRC;
    end else begin
      why = last.cls.type_why;
    end
  end

  always_comb begin
    out_word.message_kind   = (why == WHY_NONE) ? last.cls.kind : KIND_REJECT;
    out_word.reject_reason  = why;
    out_word.computed_crc   = last.crc;
    out_word.first_word     = {fr.byte_1, fr.byte_0};
    out_word.second_word    = {fr.byte_3, fr.byte_2};
    out_word.session_number = {fr.byte_5, fr.byte_4, fr.byte_3, fr.byte_2};
    out_word.payload        = {fr.byte_6, fr.byte_5, fr.byte_4, fr.byte_3,
                               fr.byte_2, fr.byte_1, fr.byte_0};
  end

endmodule

FILE: rtl/core/cfcd_classify.sv
// identifier match and per-type range checks of one frame
module cfcd_classify (
  input  cfcd_pkg::in_word_t frame,
  input  cfcd_pkg::cfg_t     cfg,
  output cfcd_pkg::cls_t     cls
);
  import cfcd_pkg::*;

  logic [10:0] id11;
  logic        ctl_bad;

  assign id11    = frame.can_id[10:0];
  assign ctl_bad = (frame.byte_4 > PctMax) || (frame.byte_5 > PctMax) ||
                   ((frame.byte_4 != 8'd0) && (frame.byte_5 != 8'd0));

  always_comb begin
    cls.kind     = KIND_REJECT;
    cls.id_bad   = 1'b0;
    cls.type_why = WHY_NONE;
    priority if (frame.can_id > StdIdMax) begin
      cls.id_bad = 1'b1;
    end else if (id11 == cfg.control_id) begin
      cls.kind = KIND_CONTROL;
      if (ctl_bad) begin
        cls.type_why = WHY_RANGE;
      end
    end else if (id11 == cfg.heartbeat_id) begin
      cls.kind = KIND_HEARTBEAT;
    end else if (id11 == cfg.diag_id) begin
      cls.kind = KIND_DIAG;
    end else if (id11 == cfg.e2e_id) begin
      cls.kind = KIND_E2E;
    end else if (id11 == cfg.status_id) begin
      cls.kind = KIND_SESSION;
      priority if (frame.byte_0 != cfg.proto_ver) begin
        cls.type_why = WHY_VERSION;
      end else if (frame.byte_1 > cfg.max_ack) begin
        cls.type_why = WHY_RANGE;
      end else begin
        cls.type_why = WHY_NONE;
      end
    end else begin
      cls.id_bad = 1'b1;
    end
  end

endmodule

FILE: rtl/core/cfcd_cell.sv
// one crc cell: folds the next byte of the queue and hands the word on
module cfcd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            valid_in,
  input  cfcd_pkg::lane_t lane_in,
  output logic            valid_r,
  output cfcd_pkg::lane_t lane_r
);
  import cfcd_pkg::*;

  lane_t lane_nxt;

  always_comb begin
    lane_nxt       = lane_in;
    lane_nxt.crc   = crc8_byte(lane_in.crc, lane_in.queue[7:0]);
    lane_nxt.queue = lane_in.queue >> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

FILE: rtl/core/cfcd_checker.sv
// port-level checks for the can frame checker, bound to the top level
module cfcd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input cfcd_pkg::in_word_t             in_word,
  input logic                           out_valid,
  input logic                           out_stall,
  input cfcd_pkg::out_word_t            out_word,
  input logic                           cfg_wr_en,
  input logic [cfcd_pkg::CfgIndexW-1:0] cfg_index,
  input logic [cfcd_pkg::CfgDataW-1:0]  cfg_wdata
);
  import cfcd_pkg::*;

  // a waiting result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // input side only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_kind_why: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.message_kind != KIND_REJECT) |->
      out_word.reject_reason == WHY_NONE)
    else $error("accepted frame carries a reject reason");

  a_why_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.reject_reason != WHY_NONE) |->
      out_word.message_kind == KIND_REJECT)
    else $error("rejected frame carries a frame type");

  a_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.payload[15:0] == out_word.first_word) &&
                  (out_word.session_number[15:0] == out_word.second_word))
    else $error("decoded words disagree with payload");

endmodule

bind can_frame_crc8_check_decode cfcd_checker u_cfcd_checker (.*);

FILE: sim/can_frame_crc8_check_decode_tb.sv
// self-checking testbench for the can frame crc-8 checker and decoder
module can_frame_crc8_check_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomWords = 292;
  localparam logic [CfgIndexW-1:0] CfgIdxUnused = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_wr_en = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  cfg_t regs_shadow = '0;
  out_word_t frame_results_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  can_frame_crc8_check_decode DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               frame_results_q.size());
      $display("** can_frame_crc8_check_decode: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // crc-8, poly 0x31, init 0, msb first over id[7:0], id[15:8], bytes 0..6
  function automatic logic [7:0] calc_crc(input in_word_t f);
    logic [71:0] stream;
    logic [7:0] crc;
    logic fb;
    stream = {f.can_id[7:0], f.can_id[15:8], f.byte_0, f.byte_1, f.byte_2,
              f.byte_3, f.byte_4, f.byte_5, f.byte_6};
    crc = 8'h00;
    for (int i = 71; i >= 0; i--) begin
      fb = crc[7] ^ stream[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  function automatic out_word_t decode_frame(input in_word_t f);
    out_word_t r;
    kind_t kind;
    reason_t why;
    logic [7:0] crc;
    crc = calc_crc(f);
    kind = KIND_REJECT;
    why = WHY_NONE;
    if (f.can_id > StdIdMax) begin
      why = WHY_UNKNOWN;
    end else if (f.can_id[10:0] == regs_shadow.control_id) begin
      kind = KIND_CONTROL;
    end else if (f.can_id[10:0] == regs_shadow.heartbeat_id) begin
      kind = KIND_HEARTBEAT;
    end else if (f.can_id[10:0] == regs_shadow.diag_id) begin
      kind = KIND_DIAG;
    end else if (f.can_id[10:0] == regs_shadow.e2e_id) begin
      kind = KIND_E2E;
    end else if (f.can_id[10:0] == regs_shadow.status_id) begin
      kind = KIND_SESSION;
    end else begin
      why = WHY_UNKNOWN;
    end
    if (why == WHY_NONE && crc != f.byte_7) begin
      why = WHY_CRC;
    end
    if (why == WHY_NONE && kind == KIND_CONTROL) begin
      if (f.byte_4 > PctMax || f.byte_5 > PctMax || (f.byte_4 != 0 && f.byte_5 != 0)) begin
        why = WHY_RANGE;
      end
    end
    if (why == WHY_NONE && kind == KIND_SESSION) begin
      if (f.byte_0 != regs_shadow.proto_ver) begin
        why = WHY_VERSION;
      end else if (f.byte_1 > regs_shadow.max_ack) begin
        why = WHY_RANGE;
      end
    end
    if (why != WHY_NONE) begin
      kind = KIND_REJECT;
    end
    r.message_kind   = kind;
    r.reject_reason  = why;
    r.computed_crc   = crc;
    r.first_word     = {f.byte_1, f.byte_0};
    r.second_word    = {f.byte_3, f.byte_2};
    r.session_number = {f.byte_5, f.byte_4, f.byte_3, f.byte_2};
    r.payload        = {f.byte_6, f.byte_5, f.byte_4, f.byte_3, f.byte_2, f.byte_1, f.byte_0};
    return r;
  endfunction

  // data is {b6,b5,b4,b3,b2,b1,b0}; byte 7 gets the matching crc
  function automatic in_word_t sealed_frame(input logic [28:0] id, input logic [55:0] data);
    in_word_t f;
    f.can_id = id;
    {f.byte_6, f.byte_5, f.byte_4, f.byte_3, f.byte_2, f.byte_1, f.byte_0} = data;
    f.byte_7 = 8'h00;
    f.byte_7 = calc_crc(f);
    return f;
  endfunction

  function automatic logic [7:0] pct_byte();
    case ($urandom_range(5))
      0, 1: return 8'd0;
      2: return PctMax;
      3: return PctMax + 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_word_t random_frame();
    in_word_t f;
    logic [10:0] ids [5];
    int unsigned k;
    ids[0] = regs_shadow.control_id;
    ids[1] = regs_shadow.heartbeat_id;
    ids[2] = regs_shadow.diag_id;
    ids[3] = regs_shadow.e2e_id;
    ids[4] = regs_shadow.status_id;
    f.can_id = 29'($urandom);
    f.byte_0 = 8'($urandom_range(255));
    f.byte_1 = 8'($urandom_range(255));
    f.byte_2 = 8'($urandom_range(255));
    f.byte_3 = 8'($urandom_range(255));
    f.byte_4 = 8'($urandom_range(255));
    f.byte_5 = 8'($urandom_range(255));
    f.byte_6 = 8'($urandom_range(255));
    f.byte_7 = 8'($urandom_range(255));
    // noise: raw ids of all widths, random crc byte
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1) == 0) begin
        f.can_id = 29'($urandom_range(2047));
      end
      return f;
    end
    k = $urandom_range(4);
    f.can_id = ($urandom_range(99) < 8) ? 29'($urandom_range(2047)) : {18'd0, ids[k]};
    if (k == 0) begin
      f.byte_4 = pct_byte();
      f.byte_5 = pct_byte();
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(1) == 0) begin
          f.byte_4 = 8'd0;
        end else begin
          f.byte_5 = 8'd0;
        end
      end
    end else if (k == 4) begin
      if ($urandom_range(99) < 85) begin
        f.byte_0 = regs_shadow.proto_ver;
      end
      if ($urandom_range(99) < 85) begin
        f.byte_1 = 8'($urandom_range(regs_shadow.max_ack, 0));
      end
    end
    if ($urandom_range(99) < 85) begin
      f.byte_7 = calc_crc(f);
    end else begin
      f.byte_7 = calc_crc(f) ^ 8'($urandom_range(255, 1));
    end
    return f;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.control_id   = 11'($urandom_range(2047));
    c.heartbeat_id = 11'($urandom_range(2047));
    c.diag_id      = 11'($urandom_range(2047));
    c.e2e_id       = 11'($urandom_range(2047));
    c.status_id    = 11'($urandom_range(2047));
    c.proto_ver    = 8'($urandom_range(255));
    c.max_ack      = 8'($urandom_range(255));
    // shared ids now and then so the match order gets exercised
    if ($urandom_range(99) < 25) begin
      c.status_id = c.heartbeat_id;
    end
    if ($urandom_range(99) < 25) begin
      c.diag_id = c.control_id;
    end
    return c;
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CONTROL_ID:   regs_shadow.control_id   = val;
      CFG_HEARTBEAT_ID: regs_shadow.heartbeat_id = val;
      CFG_DIAG_ID:      regs_shadow.diag_id      = val;
      CFG_E2E_ID:       regs_shadow.e2e_id       = val;
      CFG_SESSION_ID:   regs_shadow.status_id    = val;
      CFG_PROTO_VER:    regs_shadow.proto_ver    = val[7:0];
      CFG_MAX_ACK:      regs_shadow.max_ack      = val[7:0];
      default: ;
    endcase
  endtask

  // block must be idle; upper bits of the 8-bit registers carry junk on purpose
  task automatic program_regs(input cfg_t c);
    write_reg(CFG_CONTROL_ID, c.control_id);
    write_reg(CFG_HEARTBEAT_ID, c.heartbeat_id);
    write_reg(CFG_DIAG_ID, c.diag_id);
    write_reg(CFG_E2E_ID, c.e2e_id);
    write_reg(CFG_SESSION_ID, c.status_id);
    write_reg(CFG_PROTO_VER, {3'($urandom_range(7)), c.proto_ver});
    write_reg(CFG_MAX_ACK, {3'($urandom_range(7)), c.max_ack});
    write_reg(CfgIdxUnused, 11'($urandom_range(2047)));
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame(input in_word_t f);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= f;
    // in_stall is stable by the falling edge; the word is taken at the next rise
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    frame_results_q.push_back(decode_frame(f));
    frames_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_word);
        error_count++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("message_kind", 64'(want.message_kind), 64'(out_word.message_kind));
        check_field("reject_reason", 64'(want.reject_reason), 64'(out_word.reject_reason));
        check_field("computed_crc", 64'(want.computed_crc), 64'(out_word.computed_crc));
        check_field("first_word", 64'(want.first_word), 64'(out_word.first_word));
        check_field("second_word", 64'(want.second_word), 64'(out_word.second_word));
        check_field("session_number", 64'(want.session_number),
                    64'(out_word.session_number));
        check_field("payload", 64'(want.payload), 64'(out_word.payload));
        results_checked++;
      end
    end
  end

  // all registers are zero: id 0 is a control frame
  task automatic test_reset_defaults();
    send_frame(sealed_frame(29'h0, 56'h00_00_00_00_00_00_00));
    send_frame(sealed_frame(29'h0, 56'h9C_01_01_00_00_00_00));
    wait_idle();
  endtask

  task automatic test_frame_checks();
    cfg_t c;
    in_word_t f;
    c = '{control_id: 11'h100, heartbeat_id: 11'h200, diag_id: 11'h300,
          e2e_id: 11'h7FF, status_id: 11'h000, proto_ver: 8'h5A, max_ack: 8'h10};
    program_regs(c);
    send_frame(sealed_frame(29'h100, 56'h01_00_00_80_00_7F_FF));
    send_frame(sealed_frame(29'h100, 56'h02_00_64_12_34_56_78));
    send_frame(sealed_frame(29'h100, 56'h03_64_00_9A_BC_DE_F0));
    send_frame(sealed_frame(29'h100, 56'h04_00_65_11_22_33_44));
    send_frame(sealed_frame(29'h100, 56'h05_FF_00_55_66_77_88));
    send_frame(sealed_frame(29'h100, 56'h06_01_01_00_00_00_00));
    send_frame(sealed_frame(29'h200, 56'hFF_FF_FF_FF_FF_FF_FF));
    send_frame(sealed_frame(29'h300, 56'h00_00_00_00_00_00_00));
    send_frame(sealed_frame(29'h7FF, 56'h80_80_80_80_80_80_80));
    send_frame(sealed_frame(29'h000, 56'h07_DE_AD_BE_EF_10_5A));
    // wrong version wins over an ack that is also too large
    send_frame(sealed_frame(29'h000, 56'h08_00_00_00_01_FF_5B));
    send_frame(sealed_frame(29'h000, 56'h09_00_00_00_01_11_5A));
    f = sealed_frame(29'h200, 56'h0A_12_34_56_78_9A_BC);
    f.byte_7 ^= 8'h01;
    send_frame(f);
    // bad crc is reported ahead of a range error
    f = sealed_frame(29'h100, 56'h0B_01_01_00_00_00_00);
    f.byte_7 ^= 8'h80;
    send_frame(f);
    send_frame(sealed_frame(29'h555, 56'h0C_00_00_00_00_00_00));
    // above 0x7ff with the control id in the low bits
    send_frame(sealed_frame(29'h900, 56'h0D_00_00_00_00_00_00));
    send_frame(sealed_frame(29'h1FFF_FFFF, 56'h0E_00_00_00_00_00_00));
    send_frame(sealed_frame(29'h1000_0100, 56'h0F_00_00_00_00_00_00));
    wait_idle();
  endtask

  // same id in registers k..4: the lowest index must win
  task automatic test_id_priority();
    cfg_t c;
    for (int k = 0; k < 5; k++) begin
      c = '{control_id: 11'h2A5, heartbeat_id: 11'h2A5, diag_id: 11'h2A5,
            e2e_id: 11'h2A5, status_id: 11'h2A5, proto_ver: 8'h00, max_ack: 8'h00};
      if (k > 0) c.control_id = 11'h011;
      if (k > 1) c.heartbeat_id = 11'h012;
      if (k > 2) c.diag_id = 11'h013;
      if (k > 3) c.e2e_id = 11'h014;
      program_regs(c);
      send_frame(sealed_frame(29'h2A5, {8'(k), 48'h0}));
      wait_idle();
    end
  endtask

  task automatic run_random_words(input cfg_t c);
    program_regs(c);
    repeat (RandomWords) send_frame(random_frame());
    wait_idle();
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    send_idle_pct = 22;
    recv_idle_pct = 69;
    c = '{control_id: 11'h000, heartbeat_id: 11'h7FF, diag_id: 11'h400,
          e2e_id: 11'h3FF, status_id: 11'h001, proto_ver: 8'hFF, max_ack: 8'h00};
    run_random_words(c);
    run_random_words(random_settings());
    send_idle_pct = 69;
    recv_idle_pct = 22;
    c = '{control_id: 11'h7FF, heartbeat_id: 11'h000, diag_id: 11'h7FE,
          e2e_id: 11'h001, status_id: 11'h555, proto_ver: 8'h00, max_ack: 8'hFF};
    run_random_words(c);
    run_random_words(random_settings());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_words(random_settings());
    run_random_words(random_settings());
  endtask

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 69;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_frame_checks();
    test_id_priority();
    test_random_traffic();
    wait_idle();
    if (frame_results_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, frame_results_q.size());
      error_count++;
    end
    $display("frames sent %0d, results checked %0d, register settings %0d, errors %0d",
             frames_sent, results_checked, settings_used, error_count);
    $display("covered reset defaults, every frame type and reject reason, id match order, "
             , "and random traffic under three idle patterns");
    if (error_count == 0) begin
      $display("** can_frame_crc8_check_decode: PASSED **");
    end else begin
      $display("** can_frame_crc8_check_decode: FAILED **");
    end
    $finish;
  end

endmodule

FILE: can_frame_crc8_check_decode.f
rtl/core/cfcd_pkg.sv
rtl/core/cfcd_classify.sv
rtl/core/cfcd_cell.sv
rtl/core/can_frame_crc8_check_decode.sv
rtl/core/cfcd_checker.sv
sim/can_frame_crc8_check_decode_tb.sv
